@@ src/holding_current_calibrator_unit_defines.svh @@
// ----------------------------------------------------------------------------
// holding current calibrator assertion macros
// shared property forms, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef HOLDING_CURRENT_CALIBRATOR_UNIT_DEFINES_SVH
`define HOLDING_CURRENT_CALIBRATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define HCC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcc assertion failed");

// next-cycle implication
`define HCC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcc assertion failed");

`endif

@@ src/hcc_pkg.sv @@
// ----------------------------------------------------------------------------
// hcc_pkg
// types, constants and command structs of the holding current calibrator
// ----------------------------------------------------------------------------
`default_nettype none

package hcc_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int BURST_SAMPLES = 16;
	localparam int AVG_READINGS  = 64;
	localparam int BURST_LOG     = $clog2(BURST_SAMPLES);
	localparam int AVG_LOG       = $clog2(AVG_READINGS);

	localparam int ADC_W      = 12;
	localparam int DAC_W      = 12;
	localparam int CUR_W      = 16;
	localparam int GAIN_W     = 24;
	localparam int TICK_W     = 16;
	localparam int Q_W        = CUR_W + FRAC_BITS;
	localparam int DRIVE_W    = DAC_W + FRAC_BITS;
	localparam int BSUM_W     = ADC_W + BURST_LOG;
	localparam int RSUM_W     = CUR_W + AVG_LOG;
	localparam int RCNT_W     = AVG_LOG + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int TIMEOUT_RESET = 1000;

	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_SAMPLE = 2'd1,
		REQ_CTRL   = 2'd2,
		REQ_PROC   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_RISE    = 2'd1,
		PH_PROCESS = 2'd2,
		PH_FINISH  = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET   = 3'd0,
		CFG_CTRL_OFS = 3'd1,
		CFG_KI       = 3'd2,
		CFG_FINE     = 3'd3,
		CFG_CUR_OFS  = 3'd4,
		CFG_CONVERT  = 3'd5,
		CFG_TOL      = 3'd6,
		CFG_TIMEOUT  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [ADC_W-1:0] adc_sample;
	} hcc_req_t;

	typedef struct packed {
		logic             dac_write;
		logic [DAC_W-1:0] dac_value;
		logic             switch_on;
		logic             done_res;
		logic             problem_code;
		logic [CUR_W-1:0] result_current;
		logic [CUR_W-1:0] measured_current;
	} hcc_res_t;

	typedef struct packed {
		logic [CUR_W-1:0]        target_current;
		logic [DAC_W-1:0]        control_offset;
		logic [GAIN_W-1:0]       ki_gain;
		logic [GAIN_W-1:0]       fine_gain;
		logic signed [CUR_W-1:0] current_offset;
		logic [GAIN_W-1:0]       convert_gain;
		logic [GAIN_W-1:0]       tolerance;
		logic [TICK_W-1:0]       timeout_ticks;
	} hcc_cfg_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic mul1;
		logic mul2;
		logic mul3;
		logic fin;
		logic load_out;
	} hcc_cmd_t;

	typedef struct packed {
		logic long_op;
		logic out_free;
	} hcc_status_t;

endpackage

`default_nettype wire

@@ src/hcc_regs.sv @@
// ----------------------------------------------------------------------------
// hcc_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_regs import hcc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output hcc_cfg_t                   cfg
);

	hcc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_current <= '0;
			cfg_q.control_offset <= '0;
			cfg_q.ki_gain        <= '0;
			cfg_q.fine_gain      <= GAIN_W'(1 << FRAC_BITS);
			cfg_q.current_offset <= '0;
			cfg_q.convert_gain   <= GAIN_W'(1 << FRAC_BITS);
			cfg_q.tolerance      <= GAIN_W'(1 << FRAC_BITS);
			cfg_q.timeout_ticks  <= TICK_W'(TIMEOUT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TARGET:   cfg_q.target_current <= cfg_data[CUR_W-1:0];
				CFG_CTRL_OFS: cfg_q.control_offset <= cfg_data[DAC_W-1:0];
				CFG_KI:       cfg_q.ki_gain        <= cfg_data[GAIN_W-1:0];
				CFG_FINE:     cfg_q.fine_gain      <= cfg_data[GAIN_W-1:0];
				CFG_CUR_OFS:  cfg_q.current_offset <= $signed(cfg_data[CUR_W-1:0]);
				CFG_CONVERT:  cfg_q.convert_gain   <= cfg_data[GAIN_W-1:0];
				CFG_TOL:      cfg_q.tolerance      <= cfg_data[GAIN_W-1:0];
				CFG_TIMEOUT:  cfg_q.timeout_ticks  <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ src/hcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hcc_ctrl
// sequencer: accept, execute, optional multiply and clamp steps, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_ctrl import hcc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire hcc_status_t status,
	output hcc_cmd_t         cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EXEC = 7'b0000010,
		S_MUL1 = 7'b0000100,
		S_MUL2 = 7'b0001000,
		S_MUL3 = 7'b0010000,
		S_FIN  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = req_valid;
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.long_op ? S_MUL1 : S_OUT;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d  = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				// wait here only while the previous result is still held
				cmd.load_out = status.out_free;
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

endmodule

`default_nettype wire

@@ src/hcc_dp.sv @@
// ----------------------------------------------------------------------------
// hcc_dp
// calibration state, burst scaling, integral controller and result register
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_dp import hcc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire hcc_req_t req,
	input  wire hcc_cfg_t cfg,
	input  wire hcc_cmd_t cmd,
	output hcc_status_t   status,
	input  wire logic     res_ready,
	output logic          res_valid,
	output hcc_res_t      res
);

	localparam int RAW_W    = GAIN_W + ADC_W;
	localparam int RAW_LO_W = 18;
	localparam int RAW_HI_W = RAW_W - RAW_LO_W;
	localparam int PLO_W    = RAW_LO_W + GAIN_W;
	localparam int PHI_W    = RAW_HI_W + GAIN_W;
	localparam int FINE_W   = RAW_W + GAIN_W - FRAC_BITS;
	localparam int SUM_W    = FINE_W + 2;
	localparam int ERR_W    = Q_W + 2;
	localparam int KI_LO_W  = GAIN_W / 2;
	localparam int KI_HI_W  = GAIN_W - KI_LO_W;
	localparam int PA_W     = ERR_W + KI_LO_W + 1;
	localparam int PB_W     = ERR_W + KI_HI_W + 1;
	localparam int PROD_W   = PB_W + KI_LO_W;
	localparam int STEP_W   = PROD_W - FRAC_BITS;
	localparam int D_W      = STEP_W + 1;

	localparam logic [BURST_LOG-1:0] BURST_LAST = BURST_LOG'(BURST_SAMPLES - 1);

	// architectural state
	phase_t              phase_q;
	logic                loop_active_q;
	logic                frozen_q;
	logic                switch_q;
	logic                problem_q;
	logic [Q_W-1:0]      now_q;
	logic [DRIVE_W-1:0]  drive_q;
	logic [BSUM_W-1:0]   burst_sum_q;
	logic [BURST_LOG-1:0] burst_cnt_q;
	logic [TICK_W-1:0]   rise_ticks_q;
	logic [RCNT_W-1:0]   read_cnt_q;
	logic [RSUM_W-1:0]   read_sum_q;
	logic [CUR_W-1:0]    final_q;

	// per-item working registers
	logic [1:0]              req_type_q;
	logic [ADC_W-1:0]        sample_q;
	logic                    op_scale_q;
	logic                    dac_w_q;
	logic [DAC_W-1:0]        dac_v_q;
	logic                    done_q;
	logic                    prob_q;
	logic [ADC_W-1:0]        mean_q;
	logic [RAW_W-1:0]        raw_q;
	logic [PLO_W-1:0]        plo_q;
	logic [PHI_W-1:0]        phi_q;
	logic signed [SUM_W-1:0] base_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [PA_W-1:0]  pa_q;
	logic signed [PB_W-1:0]  pb_q;
	logic signed [PROD_W-1:0] prod_q;

	logic                    res_valid_q;
	hcc_res_t                res_q;

	// combinational
	logic [BSUM_W-1:0]       burst_next;
	logic [Q_W-1:0]          target_q;
	logic [Q_W-1:0]          diff;
	logic                    reached;
	logic signed [SUM_W-1:0] ofs_q16;
	logic signed [SUM_W-1:0] scaled;
	logic [Q_W-1:0]          scaled_clamp;
	logic signed [D_W-1:0]   drive_sum;
	logic [DRIVE_W-1:0]      drive_clamp;
	logic                    is_proc_finish;

	assign burst_next = burst_sum_q + BSUM_W'(sample_q);
	assign target_q   = {cfg.target_current, {FRAC_BITS{1'b0}}};
	assign diff       = (now_q >= target_q) ? (now_q - target_q) : (target_q - now_q);
	assign reached    = (diff < Q_W'(cfg.tolerance)) || (now_q > target_q);
	assign is_proc_finish = (req_type_q == REQ_PROC) && (phase_q == PH_FINISH);

	assign ofs_q16 = {{(SUM_W-CUR_W-FRAC_BITS){cfg.current_offset[CUR_W-1]}},
		cfg.current_offset, {FRAC_BITS{1'b0}}};

	// fine = (phi << RAW_LO_W + plo) >> FRAC_BITS, low part folded into base_q
	assign scaled = $signed({2'b00, phi_q, {(RAW_LO_W-FRAC_BITS){1'b0}}}) + base_q;

	always_comb begin
		if (scaled[SUM_W-1]) begin
			scaled_clamp = '0;
		end else if (|scaled[SUM_W-2:Q_W]) begin
			scaled_clamp = '1;
		end else begin
			scaled_clamp = scaled[Q_W-1:0];
		end
	end

	// floor of the controller product is the arithmetic right shift
	assign drive_sum = $signed({{(D_W-DRIVE_W){1'b0}}, drive_q})
		+ $signed({prod_q[PROD_W-1], prod_q[PROD_W-1:FRAC_BITS]});

	always_comb begin
		if (drive_sum[D_W-1]) begin
			drive_clamp = '0;
		end else if (drive_sum > $signed({{(D_W-DRIVE_W){1'b0}}, {DAC_W{1'b1}},
			{FRAC_BITS{1'b0}}})) begin
			drive_clamp = {{DAC_W{1'b1}}, {FRAC_BITS{1'b0}}};
		end else begin
			drive_clamp = drive_sum[DRIVE_W-1:0];
		end
	end

	assign status.long_op =
		((req_type_q == REQ_SAMPLE) && loop_active_q && (burst_cnt_q == BURST_LAST)) ||
		((req_type_q == REQ_CTRL) && loop_active_q && !frozen_q);
	assign status.out_free = !res_valid_q || res_ready;

	// architectural state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			loop_active_q <= 1'b0;
			frozen_q      <= 1'b0;
			switch_q      <= 1'b0;
			problem_q     <= 1'b0;
			now_q         <= '0;
			drive_q       <= '0;
			burst_sum_q   <= '0;
			burst_cnt_q   <= '0;
			rise_ticks_q  <= '0;
			read_cnt_q    <= '0;
			read_sum_q    <= '0;
			final_q       <= '0;
		end else if (cmd.exec) begin
			unique case (req_kind_t'(req_type_q))
				REQ_START: begin
					final_q       <= '0;
					burst_sum_q   <= '0;
					burst_cnt_q   <= '0;
					read_sum_q    <= '0;
					read_cnt_q    <= '0;
					rise_ticks_q  <= '0;
					problem_q     <= 1'b0;
					drive_q       <= {cfg.control_offset, {FRAC_BITS{1'b0}}};
					switch_q      <= 1'b1;
					frozen_q      <= 1'b0;
					loop_active_q <= 1'b1;
					phase_q       <= PH_RISE;
				end
				REQ_SAMPLE: begin
					if (loop_active_q) begin
						if (burst_cnt_q == BURST_LAST) begin
							burst_sum_q <= '0;
							burst_cnt_q <= '0;
						end else begin
							burst_sum_q <= burst_next;
							burst_cnt_q <= burst_cnt_q + 1'b1;
						end
					end
				end
				REQ_CTRL: ;
				REQ_PROC: begin
					unique case (phase_q)
						PH_RISE: begin
							// timeout is checked first and overrides reached
							if (rise_ticks_q > cfg.timeout_ticks) begin
								frozen_q  <= 1'b1;
								problem_q <= 1'b1;
								phase_q   <= PH_FINISH;
							end else if (reached) begin
								frozen_q   <= 1'b1;
								read_sum_q <= '0;
								read_cnt_q <= '0;
								phase_q    <= PH_PROCESS;
							end
							if (rise_ticks_q != '1) rise_ticks_q <= rise_ticks_q + 1'b1;
						end
						PH_PROCESS: begin
							if (read_cnt_q >= RCNT_W'(AVG_READINGS)) begin
								final_q <= read_sum_q[RSUM_W-1:AVG_LOG];
								phase_q <= PH_FINISH;
							end else begin
								read_sum_q <= read_sum_q + RSUM_W'(now_q[Q_W-1:FRAC_BITS]);
								read_cnt_q <= read_cnt_q + 1'b1;
							end
						end
						PH_FINISH: begin
							loop_active_q <= 1'b0;
							switch_q      <= 1'b0;
							phase_q       <= PH_IDLE;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end else if (cmd.fin) begin
			if (op_scale_q) begin
				now_q <= scaled_clamp;
			end else begin
				drive_q <= drive_clamp;
			end
		end
	end

	// per-item registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req.req_type;
			sample_q   <= req.adc_sample;
		end
		if (cmd.exec) begin
			op_scale_q <= (req_type_q == REQ_SAMPLE);
			dac_w_q    <= (req_type_q == REQ_CTRL) && !(loop_active_q && frozen_q);
			dac_v_q    <= '0;
			done_q     <= is_proc_finish;
			prob_q     <= is_proc_finish && problem_q;
			mean_q     <= burst_next[BSUM_W-1:BURST_LOG];
			err_q      <= $signed({2'b00, target_q}) - $signed({2'b00, now_q});
		end
		if (cmd.mul1) begin
			raw_q <= cfg.convert_gain * RAW_W'(mean_q);
			pa_q  <= err_q * $signed({1'b0, cfg.ki_gain[KI_LO_W-1:0]});
		end
		if (cmd.mul2) begin
			plo_q <= raw_q[RAW_LO_W-1:0] * cfg.fine_gain;
			pb_q  <= err_q * $signed({1'b0, cfg.ki_gain[GAIN_W-1:KI_LO_W]});
		end
		if (cmd.mul3) begin
			phi_q  <= raw_q[RAW_W-1:RAW_LO_W] * cfg.fine_gain;
			base_q <= $signed({{(SUM_W-PLO_W+FRAC_BITS){1'b0}}, plo_q[PLO_W-1:FRAC_BITS]})
				+ ofs_q16;
			prod_q <= $signed({pb_q, {KI_LO_W{1'b0}}})
				+ $signed({{(PROD_W-PA_W){pa_q[PA_W-1]}}, pa_q});
		end
		if (cmd.fin && !op_scale_q) begin
			dac_v_q <= drive_clamp[DRIVE_W-1:FRAC_BITS];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.dac_write        <= dac_w_q;
			res_q.dac_value        <= dac_v_q;
			res_q.switch_on        <= switch_q;
			res_q.done_res         <= done_q;
			res_q.problem_code     <= prob_q;
			res_q.result_current   <= final_q;
			res_q.measured_current <= now_q[Q_W-1:FRAC_BITS];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

@@ src/holding_current_calibrator_unit.sv @@
// ----------------------------------------------------------------------------
// holding_current_calibrator_unit
// holding current calibration sequencer with burst scaling and integral loop
// ----------------------------------------------------------------------------
// Items are taken one at a time and each returns exactly one result. Start,
// process ticks, control ticks on an inactive or frozen loop, and ADC samples
// that do not complete a burst go from the execute step straight to the result
// load. A sample that completes a burst and a control tick on a running loop
// pass through three multiply steps (gain products split into partial products)
// and a clamp step before the result load. A new item is accepted the cycle
// after the result is loaded, while that result may still wait on res_ready; a
// result still held when the next one is ready stalls the sequencer.
`default_nettype none

module holding_current_calibrator_unit import hcc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire hcc_req_t              req,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output hcc_res_t                   res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	hcc_cfg_t    cfg;
	hcc_cmd_t    cmd;
	hcc_status_t status;

	hcc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	hcc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

`default_nettype wire

@@ src/hcc_checker.sv @@
// ----------------------------------------------------------------------------
// hcc_checker
// port-level checks of the holding current calibrator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "holding_current_calibrator_unit_defines.svh"

module hcc_checker import hcc_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     req_valid,
	input wire logic     req_ready,
	input wire logic     res_valid,
	input wire logic     res_ready,
	input wire hcc_res_t res
);

	// a stalled result holds
	`HCC_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))
	// one item in flight: no acceptance right after another
	`HCC_ASSERT_NXT(a_one_item, req_valid && req_ready, !req_ready)
	// no drive value reported without a write
	`HCC_ASSERT_IMP(a_dac_zero, res_valid && !res.dac_write, res.dac_value == '0)
	// the finishing item turns the switch off
	`HCC_ASSERT_IMP(a_done_off, res_valid && res.done_res, !res.switch_on)
	// a problem is only reported with done
	`HCC_ASSERT_IMP(a_prob_done, res_valid && res.problem_code, res.done_res)

endmodule

bind holding_current_calibrator_unit hcc_checker u_hcc_checker (.*);

`default_nettype wire
